### sv/crsf_pkg.sv
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared constants, types and the CRC-8 (poly 0xD5) byte step.
// ----------------------------------------------------------------------------
package crsf_pkg;

    localparam int BUFFER_BYTES_DEF = 64;

    localparam logic [7:0] SYNC_A   = 8'hEE;
    localparam logic [7:0] SYNC_B   = 8'hEA;
    localparam logic [7:0] SYNC_C   = 8'hC8;
    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    localparam logic [5:0] MAX_LENGTH_RST = 6'd62;
    localparam logic [7:0] MIN_LENGTH     = 8'd2;

    localparam int          APB_ADDR_W   = 3;
    localparam int          APB_DATA_W   = 32;
    localparam logic [0:0]  REG_MAX_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_BODY
    } phase_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'd0)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/crsf_if.sv
// ----------------------------------------------------------------------------
// crsf byte channels
// Valid/ready channels for received bytes and deframed bytes.
// ----------------------------------------------------------------------------
interface crsf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crsf_data_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### sv/crsf_cfg.sv
// ----------------------------------------------------------------------------
// crsf_cfg
// APB register bank holding the max_length register.
// ----------------------------------------------------------------------------
module crsf_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [crsf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [crsf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [crsf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [5:0]                     max_length
);
    import crsf_pkg::*;

    logic [5:0] max_length_reg;
    logic       wr_en;
    logic       sel_max;

    assign pready  = 1'b1;
    assign sel_max = (paddr[APB_ADDR_W-1] == REG_MAX_LENGTH);
    assign wr_en   = psel && penable && pwrite && sel_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
        end
        else if (wr_en)
        begin
            max_length_reg <= pwdata[5:0];
        end
    end

    assign prdata     = sel_max ? {{(APB_DATA_W-6){1'b0}}, max_length_reg} : '0;
    assign max_length = max_length_reg;

endmodule

### sv/crsf_core.sv
// ----------------------------------------------------------------------------
// crsf_core
// Input register, frame parser with running CRC, and output register.
// ----------------------------------------------------------------------------
module crsf_core #(
    parameter int BUFFER_BYTES = crsf_pkg::BUFFER_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [5:0]      max_length,
    crsf_rx_if.sink         rx,
    crsf_data_if.source     tx
);
    import crsf_pkg::*;

    localparam logic [7:0] CAP = 8'(BUFFER_BYTES - 2);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] crc_reg, crc_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;

    logic       advance;
    logic       emit;
    logic [7:0] limit;
    logic       bad_len;
    logic       is_sync;
    logic [7:0] crc_step;

    assign advance  = s1_valid_reg && (!out_valid_reg || tx.ready);
    assign rx.ready = !s1_valid_reg || advance;

    assign limit    = ({2'b00, max_length} < CAP) ? {2'b00, max_length} : CAP;
    assign bad_len  = (s1_byte_reg < MIN_LENGTH) || (s1_byte_reg > limit);
    assign is_sync  = (s1_byte_reg == SYNC_A) || (s1_byte_reg == SYNC_B)
                   || (s1_byte_reg == SYNC_C);
    assign crc_step = crc8_step(crc_reg, s1_byte_reg);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:   phase_next = is_sync ? PH_LENGTH : PH_IDLE;
            PH_LENGTH: phase_next = bad_len ? PH_IDLE : PH_BODY;
            PH_BODY:   phase_next = (len_reg > 8'd1) ? PH_BODY : PH_IDLE;
            default:   phase_next = PH_IDLE;
        endcase
    end

    // datapath and result
    always_comb
    begin
        len_next = len_reg;
        crc_next = crc_reg;
        emit     = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                len_next = len_reg;
            end
            PH_LENGTH:
            begin
                if (bad_len)
                begin
                    len_next = 8'd0;
                end
                else
                begin
                    len_next = s1_byte_reg;
                    crc_next = 8'd0;
                end
            end
            PH_BODY:
            begin
                if (len_reg > 8'd1)
                begin
                    crc_next = crc_step;
                    len_next = len_reg - 8'd1;
                    emit     = 1'b1;
                end
                else
                begin
                    len_next = 8'd0;
                    emit     = (crc_reg == s1_byte_reg);
                end
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            len_reg       <= 8'd0;
            crc_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg     <= phase_next;
                len_reg       <= len_next;
                crc_reg       <= crc_next;
                out_valid_reg <= emit;
            end
            else if (tx.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
        if (advance && emit)
        begin
            out_byte_reg <= s1_byte_reg;
        end
    end

    assign tx.valid     = out_valid_reg;
    assign tx.data_byte = out_byte_reg;

endmodule

### sv/crsf_frame_deframer_crc8_top.sv
// ----------------------------------------------------------------------------
// crsf_frame_deframer_crc8_top
// CRSF deframer: sync hunt, length check, byte pass-through, CRC-8 check.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received serial byte per valid/ready transaction.
//   tx  : type and payload bytes of a frame, each as one transaction, then
//         the received CRC byte as a final transaction when the CRC matches.
//         Sync, length, rejected-length and CRC-mismatch bytes give nothing.
//   APB : register 0 (byte address 0) is max_length, 6 bits, reset 62.
//         Lengths 0, 1 and above min(max_length, BUFFER_BYTES-2) resync.
// Path: an accepted rx byte goes to the input register, then to the
//   output register that drives tx.valid; a tx stall can hold it in the input register.
// Throughput: one byte per cycle while tx is ready, with the single input
//   register and the combinational CRC byte step into the CRC register.
// Stall: while tx is held off the output register keeps its byte; the
//   input register still takes one more rx byte, then rx.ready drops.
// Reset: rst_n clears the parser to sync hunt, empties both registers and
//   restores max_length to 62.
// ----------------------------------------------------------------------------
module crsf_frame_deframer_crc8_top #(
    parameter int BUFFER_BYTES = crsf_pkg::BUFFER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crsf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [crsf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [crsf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    crsf_rx_if.sink                         rx,
    crsf_data_if.source                     tx
);
    import crsf_pkg::*;

    logic [5:0] max_length;

    crsf_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_length (max_length)
    );

    crsf_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_length (max_length),
        .rx         (rx),
        .tx         (tx)
    );

endmodule
